// File: src/assert_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SLRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SLRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/slrc_pkg.sv
package slrc_pkg;

  // Default geometry of the cache.
  localparam int unsigned SHARDS_DEF    = 8;
  localparam int unsigned WAYS_DEF      = 16;
  localparam int unsigned NODE_BITS_DEF = 32;

  // Fixed field widths of the stream beats.
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CAP_W   = 8;
  localparam int unsigned TOTAL_W = 8;
  localparam int unsigned CNTR_W  = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  // Operation codes.
  typedef enum logic [2:0] {
    FUNC_GET       = 3'd0,
    FUNC_PUT       = 3'd1,
    FUNC_ERASE     = 3'd2,
    FUNC_ERASE_VAL = 3'd3,
    FUNC_RST_STATS = 3'd4
  } func_e;

  // Status of one row update.
  typedef struct packed {
    logic hit;
    logic evicted;
    logic added;
    logic write;
  } row_flags_t;

endpackage

// File: src/sharded_lru_route_cache.sv
// The result beat of a get, put, erase, statistics reset or unused code is registered from
// the row update of the request's shard; an erase by value walks every shard row, one per cycle,
// and its result beat is loaded after the last row.
// A new request is taken only once the read-modify-write of the current one has finished
// (every row for an erase by value); a result that waits at the output stalls the next one.
// Reset clears valid flags, entry total and counters, sets capacity to 128; row RAM is kept.
module sharded_lru_route_cache #(
  parameter int unsigned SHARDS    = slrc_pkg::SHARDS_DEF,
  parameter int unsigned WAYS      = slrc_pkg::WAYS_DEF,
  parameter int unsigned NODE_BITS = slrc_pkg::NODE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request beats.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // s_axis_tdata fields from bit 0: func[2:0], key[66:3], node_value[98:67], zero fill
  input  logic [103:0] s_axis_tdata,
  // Result beats.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m_axis_tdata fields from bit 0: hit[0], value_out[32:1], evicted[33],
  // entries_total[41:34], hit_count[73:42], miss_count[105:74],
  // eviction_count[137:106], zero fill
  output logic [143:0] m_axis_tdata,
  // Capacity register writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i
);

  import slrc_pkg::*;

  localparam int unsigned SW       = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int unsigned SH_SHIFT = (SHARDS > 1) ? $clog2(SHARDS) : 0;
  localparam int unsigned AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W    = $clog2(WAYS + 1);
  localparam int unsigned EW       = KEY_W + NODE_BITS + AGE_W;
  localparam int unsigned RW       = WAYS * EW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_HOLD
  } state_e;

  state_e              state_q;
  func_e               func_q;
  logic [KEY_W-1:0]    key_q;
  logic [NODE_BITS-1:0] node_q;
  logic [SW-1:0]       row_q;
  logic [CAP_W-1:0]    cap_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [CNTR_W-1:0]   hits_q;
  logic [CNTR_W-1:0]   miss_q;
  logic [CNTR_W-1:0]   evc_q;
  logic [WAYS-1:0]     valid_q [SHARDS];
  logic                m_valid_q;
  logic [143:0]        m_data_q;
  logic [143:0]        hold_q;

  logic                accept;
  func_e               in_func;
  logic [KEY_W-1:0]    in_key;
  logic [NODE_BITS-1:0] in_node;
  logic [SW-1:0]       shard_in;
  logic                ram_re;
  logic [SW-1:0]       ram_raddr;
  logic                ram_we;
  logic [RW-1:0]       ram_rdata;
  logic [RW-1:0]       ram_wdata;
  logic [CAP_W-1:0]    cap_div;
  logic [CNT_W-1:0]    limit;
  logic                last_row;
  logic                done;
  logic                out_free;
  logic                out_load;
  logic [TOTAL_W-1:0]  total_d;
  logic [CNTR_W-1:0]   hits_d;
  logic [CNTR_W-1:0]   miss_d;
  logic [CNTR_W-1:0]   evc_d;
  logic [143:0]        result;

  logic [KEY_W-1:0]     rd_keys   [WAYS];
  logic [NODE_BITS-1:0] rd_nodes  [WAYS];
  logic [AGE_W-1:0]     rd_ages   [WAYS];
  logic [KEY_W-1:0]     wr_keys   [WAYS];
  logic [NODE_BITS-1:0] wr_nodes  [WAYS];
  logic [AGE_W-1:0]     wr_ages   [WAYS];
  logic [WAYS-1:0]      wr_valid;
  logic [NODE_BITS-1:0] hit_value;
  logic [CNT_W-1:0]     removed;
  row_flags_t           flags;

  // Unpack the request beat.
  assign in_func  = func_e'(s_axis_tdata[2:0]);
  assign in_key   = s_axis_tdata[66:3];
  assign in_node  = NODE_BITS'(s_axis_tdata[98:67]);
  assign shard_in = (SHARDS > 1) ? in_key[SW-1:0] : '0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Per-shard limit: capacity over the shard count, which is a power of two,
  // at least one and at most WAYS.
  always_comb begin
    cap_div = cap_q >> SH_SHIFT;
    if (cap_div == '0) begin
      limit = CNT_W'(1);
    end else if ({1'b0, cap_div} > 9'(WAYS)) begin
      limit = CNT_W'(WAYS);
    end else begin
      limit = CNT_W'(cap_div);
    end
  end

  // Row reads: the request's shard, or row 0 and then each next row of an erase-by-value sweep.
  assign last_row  = (row_q == SW'(SHARDS - 1));
  assign ram_re    = accept || ((state_q == ST_MOD) && (func_q == FUNC_ERASE_VAL) && !last_row);
  assign ram_raddr = accept ? ((in_func == FUNC_ERASE_VAL) ? '0 : shard_in)
                            : (row_q + SW'(1));
  assign ram_we    = (state_q == ST_MOD) && flags.write;

  slrc_ram #(
    .WIDTH (RW),
    .DEPTH (SHARDS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Split a row word into its ways and pack the updated row back.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rd_keys[w]  = ram_rdata[w*EW +: KEY_W];
      rd_nodes[w] = ram_rdata[w*EW + KEY_W +: NODE_BITS];
      rd_ages[w]  = ram_rdata[w*EW + KEY_W + NODE_BITS +: AGE_W];
      ram_wdata[w*EW +: EW] = {wr_ages[w], wr_nodes[w], wr_keys[w]};
    end
  end

  slrc_row_update #(
    .WAYS      (WAYS),
    .NODE_BITS (NODE_BITS),
    .AGE_W     (AGE_W),
    .CNT_W     (CNT_W)
  ) u_row_update (
    .op_i      (func_q),
    .key_i     (key_q),
    .node_i    (node_q),
    .limit_i   (limit),
    .valid_i   (valid_q[row_q]),
    .keys_i    (rd_keys),
    .nodes_i   (rd_nodes),
    .ages_i    (rd_ages),
    .valid_o   (wr_valid),
    .keys_o    (wr_keys),
    .nodes_o   (wr_nodes),
    .ages_o    (wr_ages),
    .value_o   (hit_value),
    .removed_o (removed),
    .flags_o   (flags)
  );

  // Counters and entry total after this row.
  always_comb begin
    total_d = total_q + TOTAL_W'(flags.added) - TOTAL_W'(removed);
    hits_d  = hits_q;
    miss_d  = miss_q;
    evc_d   = evc_q + CNTR_W'(flags.evicted);
    if (func_q == FUNC_GET) begin
      if (flags.hit) begin
        hits_d = hits_q + CNTR_W'(1);
      end else begin
        miss_d = miss_q + CNTR_W'(1);
      end
    end else if (func_q == FUNC_RST_STATS) begin
      hits_d = '0;
      miss_d = '0;
    end
    result = {6'd0, evc_d, miss_d, hits_d, total_d, flags.evicted,
              VAL_W'(hit_value), flags.hit};
  end

  assign done     = (state_q == ST_MOD) && ((func_q != FUNC_ERASE_VAL) || last_row);
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (done && out_free) || ((state_q == ST_HOLD) && m_axis_tready);

  // Sequencer, counters, valid flags and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= CAP_RESET;
      total_q   <= '0;
      hits_q    <= '0;
      miss_q    <= '0;
      evc_q     <= '0;
      m_valid_q <= 1'b0;
      func_q    <= FUNC_GET;
      row_q     <= '0;
      for (int s = 0; s < SHARDS; s++) begin
        valid_q[s] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      // The output beat is loaded by a finished update or the held result,
      // and cleared once taken.
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q  <= in_func;
            row_q   <= ram_raddr;
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (ram_we) begin
            valid_q[row_q] <= wr_valid;
          end
          total_q <= total_d;
          hits_q  <= hits_d;
          miss_q  <= miss_d;
          evc_q   <= evc_d;
          if (ram_re) begin
            row_q <= ram_raddr;
          end
          if (done) begin
            if (out_free) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= in_key;
      node_q <= in_node;
    end
    if (done) begin
      if (out_free) begin
        m_data_q <= result;
      end else begin
        hold_q <= result;
      end
    end else if ((state_q == ST_HOLD) && m_axis_tready) begin
      m_data_q <= hold_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "assert_macros.svh"

  `SLRC_ASSERT(a_accept_to_mod, accept |=> (state_q == ST_MOD), "accept without row update")
  `SLRC_ASSERT(a_hold_has_out, (state_q == ST_HOLD) |-> m_valid_q, "hold without output beat")
  `SLRC_ASSERT(a_evict_only_put, (ram_we && flags.evicted) |-> (func_q == FUNC_PUT), "bad evict")
  `SLRC_ASSERT_ALWAYS(a_no_write_idle, (state_q == ST_IDLE) |-> !ram_we, "row write while idle")

endmodule

// File: src/slrc_ram.sv
module slrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/slrc_row_update.sv
module slrc_row_update #(
  parameter int unsigned WAYS      = 16,
  parameter int unsigned NODE_BITS = 32,
  parameter int unsigned AGE_W     = 4,
  parameter int unsigned CNT_W     = 5
) (
  input  slrc_pkg::func_e                 op_i,
  input  logic [slrc_pkg::KEY_W-1:0]      key_i,
  input  logic [NODE_BITS-1:0]            node_i,
  input  logic [CNT_W-1:0]                limit_i,
  input  logic [WAYS-1:0]                 valid_i,
  input  logic [slrc_pkg::KEY_W-1:0]      keys_i  [WAYS],
  input  logic [NODE_BITS-1:0]            nodes_i [WAYS],
  input  logic [AGE_W-1:0]                ages_i  [WAYS],
  output logic [WAYS-1:0]                 valid_o,
  output logic [slrc_pkg::KEY_W-1:0]      keys_o  [WAYS],
  output logic [NODE_BITS-1:0]            nodes_o [WAYS],
  output logic [AGE_W-1:0]                ages_o  [WAYS],
  output logic [NODE_BITS-1:0]            value_o,
  output logic [CNT_W-1:0]                removed_o,
  output slrc_pkg::row_flags_t            flags_o
);

  import slrc_pkg::*;

  logic [WAYS-1:0]      match;
  logic [WAYS-1:0]      vmatch;
  logic [WAYS-1:0]      oldest;
  logic [WAYS-1:0]      kept;
  logic                 any_hit;
  logic [AGE_W-1:0]     hit_age;
  logic [NODE_BITS-1:0] hit_node;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     vcnt;
  logic [CNT_W-1:0]     sub;
  logic                 do_evict;
  logic                 free_found;

  // Key and value compares across the row, with the hit entry's age and node.
  always_comb begin
    any_hit  = 1'b0;
    hit_age  = '0;
    hit_node = '0;
    cnt      = '0;
    vcnt     = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w]  = valid_i[w] && (keys_i[w] == key_i);
      vmatch[w] = valid_i[w] && (nodes_i[w] == node_i);
      if (match[w]) begin
        any_hit  = 1'b1;
        hit_age  = ages_i[w];
        hit_node = nodes_i[w];
      end
      cnt  = cnt + CNT_W'(valid_i[w]);
      vcnt = vcnt + CNT_W'(vmatch[w]);
    end
    for (int w = 0; w < WAYS; w++) begin
      oldest[w] = valid_i[w] && (ages_i[w] == AGE_W'(cnt - CNT_W'(1)));
    end
  end

  // Read, modify and build the row that is written back.
  always_comb begin
    valid_o    = valid_i;
    keys_o     = keys_i;
    nodes_o    = nodes_i;
    ages_o     = ages_i;
    value_o    = '0;
    removed_o  = '0;
    flags_o    = '0;
    do_evict   = 1'b0;
    kept       = valid_i;
    free_found = 1'b0;
    sub        = '0;
    case (op_i)
      FUNC_GET, FUNC_PUT: begin
        if (any_hit) begin
          // Touch: younger entries age by one, the hit entry becomes newest.
          for (int w = 0; w < WAYS; w++) begin
            if (valid_i[w] && (ages_i[w] < hit_age)) begin
              ages_o[w] = ages_i[w] + AGE_W'(1);
            end
            if (match[w]) begin
              ages_o[w] = '0;
              if (op_i == FUNC_PUT) begin
                nodes_o[w] = node_i;
              end
            end
          end
          flags_o.hit   = (op_i == FUNC_GET);
          flags_o.write = 1'b1;
          value_o       = (op_i == FUNC_GET) ? hit_node : '0;
        end else if (op_i == FUNC_PUT) begin
          // Insert, evicting the oldest entry when the shard is at its limit.
          do_evict = (cnt >= limit_i) && (cnt != '0);
          if (do_evict) begin
            kept      = valid_i & ~oldest;
            removed_o = CNT_W'(1);
          end
          for (int w = 0; w < WAYS; w++) begin
            if (kept[w]) begin
              ages_o[w] = ages_i[w] + AGE_W'(1);
            end
          end
          valid_o = kept;
          for (int w = 0; w < WAYS; w++) begin
            if (!kept[w] && !free_found) begin
              free_found = 1'b1;
              valid_o[w] = 1'b1;
              keys_o[w]  = key_i;
              nodes_o[w] = node_i;
              ages_o[w]  = '0;
            end
          end
          flags_o.evicted = do_evict;
          flags_o.added   = free_found;
          flags_o.write   = 1'b1;
        end
      end
      FUNC_ERASE: begin
        if (any_hit) begin
          valid_o = valid_i & ~match;
          for (int w = 0; w < WAYS; w++) begin
            if (valid_i[w] && (ages_i[w] > hit_age)) begin
              ages_o[w] = ages_i[w] - AGE_W'(1);
            end
          end
          removed_o     = CNT_W'(1);
          flags_o.write = 1'b1;
        end
      end
      FUNC_ERASE_VAL: begin
        // Each survivor moves up by the number of removed entries newer than it.
        valid_o = valid_i & ~vmatch;
        for (int w = 0; w < WAYS; w++) begin
          sub = '0;
          for (int j = 0; j < WAYS; j++) begin
            if (vmatch[j] && (ages_i[j] < ages_i[w])) begin
              sub = sub + CNT_W'(1);
            end
          end
          ages_o[w] = ages_i[w] - AGE_W'(sub);
        end
        removed_o     = vcnt;
        flags_o.write = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sim/sharded_lru_route_cache_test.sv
`timescale 1ns / 100ps

module sharded_lru_route_cache_test;
  import slrc_pkg::*;

  localparam int unsigned N_SHARDS = SHARDS_DEF;
  localparam int unsigned N_WAYS   = WAYS_DEF;
  localparam int unsigned N_SLOTS  = N_SHARDS * N_WAYS;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = N_SHARDS + 4;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  // Codes beyond the defined operations; the block must ignore them.
  localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
  localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

  // One result beat, unpacked.
  typedef struct {
    logic                hit;
    logic [VAL_W-1:0]    value;
    logic                evicted;
    logic [TOTAL_W-1:0]  total;
    logic [CNTR_W-1:0]   hits;
    logic [CNTR_W-1:0]   misses;
    logic [CNTR_W-1:0]   evictions;
  } lookup_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic [2:0]          func;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    node;
    bit                  typed;
    logic                hit;
    logic [VAL_W-1:0]    value;
    logic [TOTAL_W-1:0]  total;
  } req_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_data_i;

  sharded_lru_route_cache uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the cache contents and counters.
  bit               sh_valid [N_SLOTS];
  logic [KEY_W-1:0] sh_key   [N_SLOTS];
  logic [VAL_W-1:0] sh_node  [N_SLOTS];
  int unsigned      sh_age   [N_SLOTS];
  logic [CNTR_W-1:0] sh_hits, sh_misses, sh_evictions;
  logic [CAP_W-1:0]  sh_capacity;

  lookup_t pending_lookups[$];
  // Typed expectations for directed rows, consumed at acceptance.
  req_row_t typed_rows[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned fails;
  int unsigned idle_cycles;
  int unsigned n_results, n_hits, n_evicts, n_by_func[8];

  function automatic int unsigned limit_per_shard();
    int unsigned lim;
    lim = sh_capacity / N_SHARDS;
    if (lim < 1) lim = 1;
    if (lim > N_WAYS) lim = N_WAYS;
    return lim;
  endfunction

  // Make a slot the most recent of its shard.
  function automatic void promote(int unsigned base, int unsigned slot);
    int unsigned age;
    age = sh_age[slot];
    for (int unsigned w = 0; w < N_WAYS; w++)
      if (sh_valid[base+w] && sh_age[base+w] < age) sh_age[base+w]++;
    sh_age[slot] = 0;
  endfunction

  function automatic void drop_slot(int unsigned base, int unsigned slot);
    int unsigned age;
    age = sh_age[slot];
    sh_valid[slot] = 0;
    for (int unsigned w = 0; w < N_WAYS; w++)
      if (sh_valid[base+w] && sh_age[base+w] > age) sh_age[base+w]--;
  endfunction

  function automatic int find_slot(int unsigned base, logic [KEY_W-1:0] key);
    for (int unsigned w = 0; w < N_WAYS; w++)
      if (sh_valid[base+w] && sh_key[base+w] == key) return int'(base + w);
    return -1;
  endfunction

  // Applies one request to the shadow cache and returns the lookup result.
  function automatic lookup_t cache_access(logic [2:0] func, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] node);
    lookup_t r;
    int unsigned base, used, oldest, oldest_age, total;
    int s;
    bit any;
    r = '{default: '0};
    base = int'(key % N_SHARDS) * N_WAYS;
    case (func)
      FUNC_GET: begin
        s = find_slot(base, key);
        if (s < 0) begin
          sh_misses++;
        end else begin
          promote(base, s);
          sh_hits++;
          r.hit = 1;
          r.value = sh_node[s];
        end
      end
      FUNC_PUT: begin
        s = find_slot(base, key);
        if (s >= 0) begin
          sh_node[s] = node;
          promote(base, s);
        end else begin
          used = 0; oldest = 0; oldest_age = 0; any = 0;
          for (int unsigned w = 0; w < N_WAYS; w++)
            if (sh_valid[base+w]) begin
              used++;
              if (!any || sh_age[base+w] > oldest_age) begin
                any = 1; oldest = base + w; oldest_age = sh_age[base+w];
              end
            end
          if (any && used >= limit_per_shard()) begin
            drop_slot(base, oldest);
            sh_evictions++;
            r.evicted = 1;
          end
          // The new key takes the first free way and becomes the most recent.
          for (int unsigned w = 0; w < N_WAYS; w++)
            if (!sh_valid[base+w]) begin
              for (int unsigned j = 0; j < N_WAYS; j++)
                if (sh_valid[base+j]) sh_age[base+j]++;
              sh_valid[base+w] = 1;
              sh_key[base+w] = key;
              sh_node[base+w] = node;
              sh_age[base+w] = 0;
              break;
            end
        end
      end
      FUNC_ERASE: begin
        s = find_slot(base, key);
        if (s >= 0) drop_slot(base, s);
      end
      FUNC_ERASE_VAL: begin
        for (int unsigned sh = 0; sh < N_SHARDS; sh++)
          for (int unsigned w = 0; w < N_WAYS; w++)
            if (sh_valid[sh*N_WAYS+w] && sh_node[sh*N_WAYS+w] == node)
              drop_slot(sh * N_WAYS, sh * N_WAYS + w);
      end
      FUNC_RST_STATS: begin
        sh_hits = '0;
        sh_misses = '0;
      end
      default: ;
    endcase
    total = 0;
    for (int unsigned i = 0; i < N_SLOTS; i++) if (sh_valid[i]) total++;
    r.total = total[TOTAL_W-1:0];
    r.hits = sh_hits;
    r.misses = sh_misses;
    r.evictions = sh_evictions;
    return r;
  endfunction

  // Clock.
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Request side monitor: predict at the edge where the beat is taken.
  always @(posedge clk_i) begin
    lookup_t r;
    req_row_t row;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r = cache_access(s_axis_tdata[2:0], s_axis_tdata[66:3], s_axis_tdata[98:67]);
      n_by_func[s_axis_tdata[2:0]]++;
      if (typed_rows.size() > 0) begin
        row = typed_rows.pop_front();
        if (row.typed) begin
          r.hit = row.hit;
          r.value = row.value;
          r.total = row.total;
        end
      end
      pending_lookups = {pending_lookups, r};
    end
  end

  // Result side monitor: compare against the oldest expectation.
  always @(posedge clk_i) begin
    lookup_t e, a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.hit = m_axis_tdata[0];
      a.value = m_axis_tdata[32:1];
      a.evicted = m_axis_tdata[33];
      a.total = m_axis_tdata[41:34];
      a.hits = m_axis_tdata[73:42];
      a.misses = m_axis_tdata[105:74];
      a.evictions = m_axis_tdata[137:106];
      n_results++;
      if (a.hit) n_hits++;
      if (a.evicted) n_evicts++;
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
        fails++;
      end else begin
        e = pending_lookups.pop_front();
        if (a.hit !== e.hit) begin
          $display("%0t: hit expected %0h got %0h", $time, e.hit, a.hit); fails++;
        end
        if (a.value !== e.value) begin
          $display("%0t: value expected %0h got %0h", $time, e.value, a.value); fails++;
        end
        if (a.evicted !== e.evicted) begin
          $display("%0t: evicted expected %0h got %0h", $time, e.evicted, a.evicted); fails++;
        end
        if (a.total !== e.total) begin
          $display("%0t: total expected %0d got %0d", $time, e.total, a.total); fails++;
        end
        if (a.hits !== e.hits) begin
          $display("%0t: hits expected %0d got %0d", $time, e.hits, a.hits); fails++;
        end
        if (a.misses !== e.misses) begin
          $display("%0t: misses expected %0d got %0d", $time, e.misses, a.misses); fails++;
        end
        if (a.evictions !== e.evictions) begin
          $display("%0t: evictions expected %0d got %0d", $time, e.evictions, a.evictions);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat moving.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result receiver, with random stalls and an occasional long hold-off.
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk_i);
        hold_req = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_req(logic [2:0] func, logic [KEY_W-1:0] key, logic [VAL_W-1:0] node);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {5'd0, node, key, func};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // Waits until every result is back and the block has settled.
  task automatic wait_quiet();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_quiet();
    cfg_valid_i <= 1;
    cfg_data_i <= cap;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 0;
    sh_capacity = cap;
  endtask

  task automatic send_row(req_row_t row);
    typed_rows = {typed_rows, row};
    send_req(row.func, row.key, row.node);
  endtask

  function automatic req_row_t mk(logic [2:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] n);
    mk = '{func: f, key: k, node: n, typed: 0, hit: 0, value: '0, total: '0};
  endfunction

  function automatic req_row_t mkt(logic [2:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] n,
                                   logic h, logic [VAL_W-1:0] v, logic [TOTAL_W-1:0] t);
    mkt = '{func: f, key: k, node: n, typed: 1, hit: h, value: v, total: t};
  endfunction

  initial begin
    req_row_t         directed[20];
    logic [KEY_W-1:0] key_pool[$];
    logic [VAL_W-1:0] node_pool[6];
    logic [CAP_W-1:0] caps[7];
    logic [2:0]       f;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] n;
    int unsigned      pick;

    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    hold_req = 0;
    fails = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_results = 0; n_hits = 0; n_evicts = 0;
    foreach (n_by_func[i]) n_by_func[i] = 0;
    foreach (sh_valid[i]) begin
      sh_valid[i] = 0; sh_key[i] = '0; sh_node[i] = '0; sh_age[i] = 0;
    end
    sh_hits = '0; sh_misses = '0; sh_evictions = '0;
    sh_capacity = CAP_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part: empty cache, extreme keys and nodes, updates, erases,
    // erase by value over several entries, statistics reset and spare codes.
    directed = '{
      mkt(FUNC_GET, '0, '0, 0, '0, 0),
      mkt(FUNC_PUT, '0, '1, 0, '0, 1),
      mkt(FUNC_GET, '0, '0, 1, '1, 1),
      mkt(FUNC_PUT, '1, '0, 0, '0, 2),
      mkt(FUNC_GET, '1, '1, 1, '0, 2),
      mkt(FUNC_PUT, '0, 32'd5, 0, '0, 2),
      mkt(FUNC_GET, '0, '0, 1, 32'd5, 2),
      mkt(FUNC_ERASE, 64'd8, '0, 0, '0, 2),
      mkt(FUNC_ERASE_VAL, '1, 32'd5, 0, '0, 1),
      mk(FUNC_RST_STATS, '0, '0),
      mkt(FUNC_SPARE_LO, '1, '1, 0, '0, 1),
      mkt(FUNC_SPARE_MID, '0, '1, 0, '0, 1),
      mkt(FUNC_SPARE_HI, '1, '0, 0, '0, 1),
      mkt(FUNC_ERASE, '1, '0, 0, '0, 0),
      mkt(FUNC_PUT, 64'd16, 32'd7, 0, '0, 1),
      mkt(FUNC_PUT, 64'd17, 32'd7, 0, '0, 2),
      mkt(FUNC_PUT, 64'hA5A5_5A5A_F0F0_0F0F, 32'h8000_0001, 0, '0, 3),
      mkt(FUNC_ERASE_VAL, '0, 32'd7, 0, '0, 1),
      mk(FUNC_GET, 64'hA5A5_5A5A_F0F0_0F0F, '0),
      mk(FUNC_GET, 64'd16, '0)
    };
    foreach (directed[i]) send_row(directed[i]);

    // Random phases, each under its own capacity and one of four idling patterns.
    caps = '{CAP_RESET, 8'd1, 8'd0, 8'd255, 8'd24, 8'd64, 8'($urandom_range(2, 127))};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // A small key pool per phase keeps shards busy so that gets hit and puts evict.
      key_pool.delete();
      for (int i = 0; i < 40; i++) begin
        k = {$urandom, $urandom};
        key_pool = {key_pool, k};
      end
      foreach (node_pool[i]) node_pool[i] = $urandom;
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 0 && i == 100) hold_req = 1;
        if (p == 2 && i == 120) wait_quiet();
        pick = $urandom_range(99);
        if (pick < 35) f = FUNC_GET;
        else if (pick < 77) f = FUNC_PUT;
        else if (pick < 87) f = FUNC_ERASE;
        else if (pick < 93) f = FUNC_ERASE_VAL;
        else if (pick < 97) f = FUNC_RST_STATS;
        else f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                     : key_pool[$urandom_range(key_pool.size() - 1)];
        n = ($urandom_range(9) == 0) ? $urandom : node_pool[$urandom_range(5)];
        send_row(mk(f, k, n));
      end
    end

    wait_quiet();
    $display("Covered %0d results: %0d gets, %0d puts, %0d erases, %0d value erases,",
             n_results, n_by_func[FUNC_GET], n_by_func[FUNC_PUT], n_by_func[FUNC_ERASE],
             n_by_func[FUNC_ERASE_VAL]);
    $display("%0d hits and %0d evictions over %0d capacity settings.", n_hits, n_evicts,
             $size(caps));
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sharded_lru_route_cache.f
+incdir+src
src/slrc_pkg.sv
src/slrc_ram.sv
src/slrc_row_update.sv
src/sharded_lru_route_cache.sv
sim/sharded_lru_route_cache_test.sv
